/* rtl/core/srum_pkg.sv */
// Package for the scanline region union merge: span, transaction and status types.
// Shared by every module under rtl/core; depends on nothing else.
package srum_pkg;

  // Coordinate width is fixed by the transaction fields
  localparam int COORD_BITS       = 12;
  localparam int REGION_IDX_BITS  = 3;
  localparam int NUM_REGIONS_DEF  = 8;
  localparam int INTERVALS_DEF    = 64;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One scan interval, ordered row, left, right from the top bit down
  typedef struct packed {
    coord_t row;
    coord_t left;
    coord_t right;
  } span_t;

  typedef enum logic [0:0] {
    FUNC_LOAD = 1'b0,
    FUNC_PULL = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_FULL   = 3'd1,
    ST_BUSY   = 3'd2,
    ST_EMIT   = 3'd3,
    ST_DONE   = 3'd4
  } status_t;

  typedef struct packed {
    func_t                      func;
    logic [REGION_IDX_BITS-1:0] region_index;
    coord_t                     row_y;
    coord_t                     left_x;
    coord_t                     right_x;
  } in_t;

  typedef struct packed {
    status_t status;
    coord_t  out_row;
    coord_t  out_left;
    coord_t  out_right;
  } out_t;

  // Flags from the shared span compare unit
  typedef struct packed {
    logic less;   // a orders strictly before b
    logic touch;  // b on the same row as a and starts at most one past a's right end
    logic raise;  // b's right end lies beyond a's right end
  } cmp_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } seq_state_t;

endpackage

/* rtl/core/srum_span_alu.sv */
// Shared span compare unit: ordering, adjacency and right-end test of two spans.
// Depends on srum_pkg.
module srum_span_alu (
  input  srum_pkg::span_t    op_a,
  input  srum_pkg::span_t    op_b,
  output srum_pkg::cmp_res_t res
);

  logic [srum_pkg::COORD_BITS:0] a_right_inc;

  // Widen before the increment so the right edge of the row does not wrap
  assign a_right_inc = {1'b0, op_a.right} + {{srum_pkg::COORD_BITS{1'b0}}, 1'b1};

  // Row, left, right order is one compare of the packed span
  assign res.less  = op_a < op_b;
  assign res.touch = (op_a.row == op_b.row) && ({1'b0, op_b.left} <= a_right_inc);
  assign res.raise = op_b.right > op_a.right;

endmodule

/* rtl/core/srum_span_mem.sv */
// Interval store: one write port, one read port with registered read data.
// Depends on srum_pkg for the span type.
module srum_span_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  srum_pkg::span_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output srum_pkg::span_t rd_data_r
);

  srum_pkg::span_t mem [DEPTH];

  // Write on load
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle; read data is registered and valid in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/core/scanline_region_union_merge.sv */
// Top level of the scanline region union merge: sequencer, list counters, result register.
// Depends on srum_pkg, srum_span_alu and srum_span_mem.
//
// Channel | Ports                          | Handshake
// --------+--------------------------------+------------------------------------
// input   | start, busy, in_item (in_t)    | transaction taken when start && !busy
// result  | out_strobe, out_item (out_t)   | one cycle per result, no backpressure
//
// A load's result strobes in the next cycle, when busy is already low.
// A pull scans all NUM_REGIONS list heads through the one read port of the interval store,
// each scan followed by a decide in S_DECIDE. A pull that takes k heads runs k+1 scans,
// and its result strobes in the cycle busy falls.
// Reset is synchronous, active low, and clears every list; the store needs no clearing.
// The receiver cannot stall: each result is flagged by out_strobe for exactly one cycle.
module scanline_region_union_merge #(
  parameter int NUM_REGIONS          = srum_pkg::NUM_REGIONS_DEF,
  parameter int INTERVALS_PER_REGION = srum_pkg::INTERVALS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  srum_pkg::in_t    in_item,
  output logic             out_strobe,
  output srum_pkg::out_t   out_item
);

  localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CW    = $clog2(INTERVALS_PER_REGION + 1);
  localparam int PW    = (INTERVALS_PER_REGION > 1) ? $clog2(INTERVALS_PER_REGION) : 1;
  localparam int SW    = $clog2(NUM_REGIONS + 1);
  localparam int AW    = RW + PW;
  localparam int DEPTH = NUM_REGIONS * (2 ** PW);

  srum_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [RW-1:0]        s1_reg_r, s1_reg_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [RW-1:0]        best_reg_r, best_reg_nxt;
  srum_pkg::span_t      best_r, best_nxt;
  logic                 have_pend_r, have_pend_nxt;
  srum_pkg::span_t      pend_r, pend_nxt;
  logic                 merging_r, merging_nxt;
  logic [CW-1:0]        count_r    [NUM_REGIONS];
  logic [CW-1:0]        count_nxt  [NUM_REGIONS];
  logic [CW-1:0]        read_pos_r   [NUM_REGIONS];
  logic [CW-1:0]        read_pos_nxt [NUM_REGIONS];
  logic                 out_strobe_r, out_strobe_nxt;
  srum_pkg::out_t       out_item_r, out_item_nxt;

  logic [RW-1:0]        idx;
  logic [CW-1:0]        cnt_sel;
  logic [CW-1:0]        pos_sel;
  logic                 issue;
  logic                 nonempty;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  srum_pkg::span_t      wr_data;
  srum_pkg::span_t      rd_data;
  srum_pkg::span_t      alu_a;
  srum_pkg::cmp_res_t   alu_res;

  // Pick the one list index in use this cycle
  always_comb begin
    unique case (state_r)
      srum_pkg::S_IDLE:   idx = RW'(in_item.region_index);
      srum_pkg::S_SCAN:   idx = scan_r[RW-1:0];
      srum_pkg::S_DECIDE: idx = best_reg_r;
      default:            idx = best_reg_r;
    endcase
  end

  assign cnt_sel  = count_r[idx];
  assign pos_sel  = read_pos_r[idx];
  assign issue    = int'(scan_r) < NUM_REGIONS;
  assign nonempty = pos_sel < cnt_sel;
  assign rd_addr  = {idx, pos_sel[PW-1:0]};
  assign wr_addr  = {idx, cnt_sel[PW-1:0]};
  assign wr_data  = '{row: in_item.row_y, left: in_item.left_x, right: in_item.right_x};

  // Compare the head just read against the best, or the pending span against the best
  assign alu_a = (state_r == srum_pkg::S_DECIDE) ? pend_r : rd_data;

  srum_span_alu u_alu (
    .op_a (alu_a),
    .op_b (best_r),
    .res  (alu_res)
  );

  srum_span_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Sequencer: next state, list updates and result
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    s1_vld_nxt     = 1'b0;
    s1_reg_nxt     = s1_reg_r;
    best_vld_nxt   = best_vld_r;
    best_reg_nxt   = best_reg_r;
    best_nxt       = best_r;
    have_pend_nxt  = have_pend_r;
    pend_nxt       = pend_r;
    merging_nxt    = merging_r;
    count_nxt      = count_r;
    read_pos_nxt   = read_pos_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    wr_en          = 1'b0;

    unique case (state_r)
      srum_pkg::S_IDLE: begin
        if (start) begin
          if (in_item.func == srum_pkg::FUNC_LOAD) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '0;
            if (merging_r) begin
              out_item_nxt.status = srum_pkg::ST_BUSY;
            end else if ((int'(in_item.region_index) >= NUM_REGIONS) ||
                         (cnt_sel == CW'(INTERVALS_PER_REGION))) begin
              out_item_nxt.status = srum_pkg::ST_FULL;
            end else begin
              wr_en               = 1'b1;
              count_nxt[idx]      = cnt_sel + CW'(1);
              out_item_nxt.status = srum_pkg::ST_LOADED;
            end
          end else begin
            merging_nxt  = 1'b1;
            scan_nxt     = '0;
            best_vld_nxt = 1'b0;
            state_nxt    = srum_pkg::S_SCAN;
          end
        end
      end

      srum_pkg::S_SCAN: begin
        // Issue the head of this region, compare the one read last cycle
        s1_vld_nxt = issue && nonempty;
        s1_reg_nxt = idx;
        if (s1_vld_r && (!best_vld_r || alu_res.less)) begin
          best_nxt     = rd_data;
          best_vld_nxt = 1'b1;
          best_reg_nxt = s1_reg_r;
        end
        if (issue) begin
          scan_nxt = scan_r + SW'(1);
        end else begin
          state_nxt = srum_pkg::S_DECIDE;
        end
      end

      srum_pkg::S_DECIDE: begin
        if (!best_vld_r) begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '0;
          state_nxt      = srum_pkg::S_IDLE;
          have_pend_nxt  = 1'b0;
          if (have_pend_r) begin
            out_item_nxt = '{status: srum_pkg::ST_EMIT, out_row: pend_r.row,
                             out_left: pend_r.left, out_right: pend_r.right};
          end else begin
            // All lists drained: end the job and empty every list
            out_item_nxt.status = srum_pkg::ST_DONE;
            merging_nxt         = 1'b0;
            for (int r = 0; r < NUM_REGIONS; r++) begin
              count_nxt[r]    = '0;
              read_pos_nxt[r] = '0;
            end
          end
        end else if (!have_pend_r || alu_res.touch) begin
          // Take the best head, or absorb it into the pending span
          if (!have_pend_r) begin
            pend_nxt      = best_r;
            have_pend_nxt = 1'b1;
          end else if (alu_res.raise) begin
            pend_nxt.right = best_r.right;
          end
          read_pos_nxt[idx] = pos_sel + CW'(1);
          scan_nxt          = '0;
          best_vld_nxt      = 1'b0;
          state_nxt         = srum_pkg::S_SCAN;
        end else begin
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{status: srum_pkg::ST_EMIT, out_row: pend_r.row,
                             out_left: pend_r.left, out_right: pend_r.right};
          have_pend_nxt  = 1'b0;
          state_nxt      = srum_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = srum_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srum_pkg::S_IDLE;
      scan_r       <= '0;
      s1_vld_r     <= 1'b0;
      best_vld_r   <= 1'b0;
      have_pend_r  <= 1'b0;
      merging_r    <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        count_r[r]    <= '0;
        read_pos_r[r] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      s1_vld_r     <= s1_vld_nxt;
      best_vld_r   <= best_vld_nxt;
      have_pend_r  <= have_pend_nxt;
      merging_r    <= merging_nxt;
      out_strobe_r <= out_strobe_nxt;
      count_r      <= count_nxt;
      read_pos_r   <= read_pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_reg_r   <= s1_reg_nxt;
    best_reg_r <= best_reg_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != srum_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef NO_ASSERTIONS
  // A pull ends with exactly its result in the cycle busy drops
  a_pull_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("pull finished without a result");

  // A load answers in the next cycle and leaves the block free
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.func == srum_pkg::FUNC_LOAD) |=> (out_strobe && !busy))
    else $error("load result missing");

  // The finished answer closes the job
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == srum_pkg::ST_DONE) |-> !merging_r)
    else $error("job still open after finished result");

  // No interval is stored while a merge is open
  a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == srum_pkg::ST_LOADED) |-> !merging_r)
    else $error("interval loaded during a merge");
`endif

endmodule

/* tb/srum_union_checker.sv */
`timescale 1ns / 1ps
// Result checker for the scanline region union merge: predicts every transaction's answer.
// Depends on srum_pkg; watches the input and result channels of the block from outside.
module srum_union_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  srum_pkg::in_t  in_item,
  input  logic           out_strobe,
  input  srum_pkg::out_t out_item,
  output int             fail_count,
  output int             results_owed
);

  localparam int LISTS = srum_pkg::NUM_REGIONS_DEF;
  localparam int DEPTH = srum_pkg::INTERVALS_DEF;
  localparam int PRINT_CAP = 100;

  // Shadow copy of the region lists and the merge cursor
  srum_pkg::span_t lists [LISTS][DEPTH];
  int unsigned     fill  [LISTS];
  int unsigned     taken [LISTS];
  srum_pkg::span_t acc;
  bit              acc_valid;
  bit              in_merge;

  srum_pkg::out_t answers_due [$];

  task automatic flag_error(input string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_lists();
    for (int i = 0; i < LISTS; i++) begin
      fill[i] = 0;
      taken[i] = 0;
    end
  endfunction

  // Order by row, then left, then right
  function automatic bit span_before(input srum_pkg::span_t a, input srum_pkg::span_t b);
    if (a.row != b.row) return a.row < b.row;
    if (a.left != b.left) return a.left < b.left;
    return a.right < b.right;
  endfunction

  // Same row and starting at most one column past the current right end (no wrap)
  function automatic bit joins(input srum_pkg::span_t cur, input srum_pkg::span_t h);
    logic [srum_pkg::COORD_BITS:0] reach;
    reach = {1'b0, cur.right} + 1'b1;
    return (h.row == cur.row) && ({1'b0, h.left} <= reach);
  endfunction

  // Region holding the smallest unread head, -1 when every list is used up
  function automatic int head_pick();
    int best;
    best = -1;
    for (int i = 0; i < LISTS; i++) begin
      if (taken[i] < fill[i]) begin
        if (best < 0 || span_before(lists[i][taken[i]], lists[best][taken[best]])) best = i;
      end
    end
    return best;
  endfunction

  // Apply one transaction to the shadow state and return the answer it must produce
  function automatic srum_pkg::out_t union_step(input srum_pkg::in_t item);
    srum_pkg::out_t  res;
    int              r;
    int              idx;
    srum_pkg::span_t h;
    res = '0;
    idx = int'(item.region_index);
    if (item.func == srum_pkg::FUNC_LOAD) begin
      if (in_merge) begin
        res.status = srum_pkg::ST_BUSY;
      end else if (idx >= LISTS || fill[idx] >= DEPTH) begin
        res.status = srum_pkg::ST_FULL;
      end else begin
        lists[idx][fill[idx]].row = item.row_y;
        lists[idx][fill[idx]].left = item.left_x;
        lists[idx][fill[idx]].right = item.right_x;
        fill[idx]++;
        res.status = srum_pkg::ST_LOADED;
      end
      return res;
    end
    in_merge = 1'b1;
    if (!acc_valid) begin
      r = head_pick();
      if (r < 0) begin
        // Nothing left: close the job and empty every list
        in_merge = 1'b0;
        clear_lists();
        res.status = srum_pkg::ST_DONE;
        return res;
      end
      acc = lists[r][taken[r]];
      taken[r]++;
      acc_valid = 1'b1;
    end
    // Absorb every touching head; keep the larger right end
    r = head_pick();
    while (r >= 0) begin
      h = lists[r][taken[r]];
      if (!joins(acc, h)) break;
      if (h.right > acc.right) acc.right = h.right;
      taken[r]++;
      r = head_pick();
    end
    res.status = srum_pkg::ST_EMIT;
    res.out_row = acc.row;
    res.out_left = acc.left;
    res.out_right = acc.right;
    acc_valid = 1'b0;
    return res;
  endfunction

  // Check results against the oldest prediction, then queue the new transaction's answer
  always @(posedge clk) begin
    srum_pkg::out_t want;
    srum_pkg::out_t fresh;
    if (!rst_n) begin
      clear_lists();
      acc = '0;
      acc_valid = 1'b0;
      in_merge = 1'b0;
      answers_due.delete();
    end else begin
      if (out_strobe) begin
        if (answers_due.size() == 0) begin
          flag_error($sformatf("unexpected result status=%0d row=%0d left=%0d right=%0d",
                               out_item.status, out_item.out_row, out_item.out_left,
                               out_item.out_right));
        end else begin
          want = answers_due.pop_front();
          if (out_item.status !== want.status)
            flag_error($sformatf("status got %0d want %0d", out_item.status, want.status));
          if (out_item.out_row !== want.out_row)
            flag_error($sformatf("out_row got %0d want %0d", out_item.out_row, want.out_row));
          if (out_item.out_left !== want.out_left)
            flag_error($sformatf("out_left got %0d want %0d", out_item.out_left,
                                 want.out_left));
          if (out_item.out_right !== want.out_right)
            flag_error($sformatf("out_right got %0d want %0d", out_item.out_right,
                                 want.out_right));
        end
      end
      if (start && !busy) begin
        fresh = union_step(in_item);
        answers_due.insert(answers_due.size(), fresh);
      end
    end
    results_owed = answers_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the scanline region union merge regression: clock, reset, stimulus and verdict.
// Depends on srum_pkg, the block scanline_region_union_merge and srum_union_checker.
module testbench;

  localparam int LISTS = srum_pkg::NUM_REGIONS_DEF;
  localparam int DEPTH = srum_pkg::INTERVALS_DEF;
  localparam int TARGET_ITEMS = 1700;
  localparam int IN_BITS = $bits(srum_pkg::in_t);

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  srum_pkg::in_t  in_item;
  logic           out_strobe;
  srum_pkg::out_t out_item;
  int             fail_count;
  int             results_owed;

  int items_sent;
  bit quiet;
  int held [LISTS];

  scanline_region_union_merge uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  srum_union_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_strobe   (out_strobe),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  initial begin
    #1_000_000;
    $display("scanline_region_union_merge regression: fail");
    $finish;
  end

  function automatic srum_pkg::in_t random_bits();
    logic [63:0] bits64;
    bits64 = {$urandom, $urandom};
    return bits64[IN_BITS-1:0];
  endfunction

  function automatic srum_pkg::in_t make_load(input int r, input int row, input int left,
                                              input int right);
    srum_pkg::in_t it;
    it.func = srum_pkg::FUNC_LOAD;
    it.region_index = srum_pkg::REGION_IDX_BITS'(r);
    it.row_y = srum_pkg::coord_t'(row);
    it.left_x = srum_pkg::coord_t'(left);
    it.right_x = srum_pkg::coord_t'(right);
    return it;
  endfunction

  // Pull carries random bits in the unused fields
  function automatic srum_pkg::in_t make_pull();
    srum_pkg::in_t it;
    it = random_bits();
    it.func = srum_pkg::FUNC_PULL;
    return it;
  endfunction

  // Drive one transaction after a random idle gap and hold it until taken
  task automatic issue(input srum_pkg::in_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      in_item <= random_bits();
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Hold off until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic note_load(input int r);
    if (held[r] < DEPTH) held[r]++;
  endtask

  // One job: a batch of loads, then pulls with stray loads until the union is finished (or cut short)
  task automatic run_job();
    int               kind;
    int               n_loads;
    int               n_pulls;
    int               total;
    int               r;
    int               target;
    int               left;
    int               right;
    bit               wide;
    bit               broken;
    srum_pkg::coord_t row_at [LISTS];
    srum_pkg::coord_t col_at [LISTS];
    kind = $urandom_range(0, 19);
    wide = ($urandom_range(0, 3) == 0);
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < LISTS; i++) begin
      row_at[i] = wide ? srum_pkg::coord_t'($urandom_range(0, 4095)) :
                         srum_pkg::coord_t'($urandom_range(0, 3));
      col_at[i] = wide ? srum_pkg::coord_t'($urandom_range(0, 4095)) :
                         srum_pkg::coord_t'($urandom_range(0, 20));
    end
    target = $urandom_range(0, LISTS - 1);
    n_loads = (kind == 0) ? DEPTH + $urandom_range(1, 4) : $urandom_range(1, 24);
    for (int n = 0; n < n_loads; n++) begin
      // Overfill one list in fill jobs, otherwise spread over all regions
      r = (kind == 0 && $urandom_range(0, 7) != 0) ? target : $urandom_range(0, LISTS - 1);
      if ($urandom_range(0, 11) == 0) begin
        issue(make_load(r, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095)));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          row_at[r] = row_at[r] + srum_pkg::coord_t'($urandom_range(0, 2));
          col_at[r] = wide ? srum_pkg::coord_t'($urandom_range(0, 4095)) :
                             srum_pkg::coord_t'($urandom_range(0, 20));
        end
        left = int'(col_at[r]) + $urandom_range(0, 4);
        right = left + $urandom_range(0, 6);
        col_at[r] = srum_pkg::coord_t'(right);
        issue(make_load(r, int'(row_at[r]), left, right));
      end
      note_load(r);
    end
    total = 2;
    for (int i = 0; i < LISTS; i++) total += held[i];
    broken = ($urandom_range(0, 7) == 0);
    n_pulls = broken ? $urandom_range(1, total) : total;
    for (int n = 0; n < n_pulls; n++) begin
      // Stray load while the merge runs
      if (n > 0 && $urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, LISTS - 1);
        issue(make_load(r, $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095)));
        note_load(r);
      end
      issue(make_pull());
    end
    if (!broken) begin
      for (int i = 0; i < LISTS; i++) held[i] = 0;
    end
    if ($urandom_range(0, 4) == 0) drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    items_sent = 0;
    quiet = 1'b0;
    for (int i = 0; i < LISTS; i++) held[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: pull with nothing loaded
    issue(make_pull());
    // Extremes, adjacency, reversed and unsorted intervals, wrap of right end plus one
    issue(make_load(0, 0, 0, 0));
    issue(make_load(7, 4095, 4095, 4095));
    issue(make_load(1, 0, 1, 5));
    issue(make_load(2, 0, 6, 2));
    issue(make_load(3, 4095, 0, 4094));
    issue(make_load(4, 4095, 4095, 0));
    issue(make_load(6, 12'hAAA, 12'h555, 12'hAAA));
    issue(make_load(6, 12'h555, 12'hAAA, 12'h555));
    issue(make_load(5, 0, 7, 9));
    issue(make_pull());
    // Load during merge
    issue(make_load(0, 1, 2, 3));
    repeat (11) issue(make_pull());
    drain_results();

    // Random jobs
    while (items_sent < TARGET_ITEMS) run_job();

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("scanline_region_union_merge regression: pass");
    end else begin
      $display("scanline_region_union_merge regression: fail");
    end
    $finish;
  end

endmodule
